[rtl/core/pss_pkg.sv]
// pss_pkg: shared types, constants and the percent-to-pwm table for the pump soft-start ramp
// no dependencies; used by pss_core and pump_soft_start_ramp_top

package pss_pkg;

    // default ramp shape in 50 ms ticks
    localparam int UpStepsDef    = 60;
    localparam int HoldTicksDef  = 20;
    localparam int DownStepsDef  = 20;

    localparam int MidPercent    = 50;
    localparam int MaxPercent    = 100;
    localparam int PumpMinReset  = 0;
    localparam int PumpMaxReset  = 100;

    localparam int PctW          = 7;
    localparam int PwmW          = 8;
    localparam int StepW         = 7;
    localparam int TargetW       = 6;
    localparam int ReqW          = 8;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_UP   = 2'd1,
        PH_HOLD = 2'd2,
        PH_DOWN = 2'd3
    } t_phase;

    typedef enum logic {
        FUNC_SET  = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    typedef enum logic {
        REG_PUMP_MIN = 1'b0,
        REG_PUMP_MAX = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_func               func;
        logic [ReqW-1:0]     target_percent;
        logic                manual_mode;
        logic                force_mode;
        logic                emergency_mode;
    } t_item;

    typedef struct packed {
        logic [PwmW-1:0] pwm_level;
        logic            ramp_busy;
    } t_result;

    typedef struct packed {
        logic [PctW-1:0] pump_min_percent;
        logic [PctW-1:0] pump_max_percent;
    } t_cfg;

    // floor(p * 255 / 100) for p = 0..100
    localparam logic [PwmW-1:0] PctToPwm [0:MaxPercent] = '{
        8'd0,   8'd2,   8'd5,   8'd7,   8'd10,  8'd12,  8'd15,  8'd17,  8'd20,  8'd22,
        8'd25,  8'd28,  8'd30,  8'd33,  8'd35,  8'd38,  8'd40,  8'd43,  8'd45,  8'd48,
        8'd51,  8'd53,  8'd56,  8'd58,  8'd61,  8'd63,  8'd66,  8'd68,  8'd71,  8'd73,
        8'd76,  8'd79,  8'd81,  8'd84,  8'd86,  8'd89,  8'd91,  8'd94,  8'd96,  8'd99,
        8'd102, 8'd104, 8'd107, 8'd109, 8'd112, 8'd114, 8'd117, 8'd119, 8'd122, 8'd124,
        8'd127, 8'd130, 8'd132, 8'd135, 8'd137, 8'd140, 8'd142, 8'd145, 8'd147, 8'd150,
        8'd153, 8'd155, 8'd158, 8'd160, 8'd163, 8'd165, 8'd168, 8'd170, 8'd173, 8'd175,
        8'd178, 8'd181, 8'd183, 8'd186, 8'd188, 8'd191, 8'd193, 8'd196, 8'd198, 8'd201,
        8'd204, 8'd206, 8'd209, 8'd211, 8'd214, 8'd216, 8'd219, 8'd221, 8'd224, 8'd226,
        8'd229, 8'd232, 8'd234, 8'd237, 8'd239, 8'd242, 8'd244, 8'd247, 8'd249, 8'd252,
        8'd255
    };

    function automatic logic [PwmW-1:0] pct_to_pwm(input logic [PctW-1:0] pct);
        logic [PctW-1:0] lim;
        lim = (pct > PctW'(MaxPercent)) ? PctW'(MaxPercent) : pct;
        return PctToPwm[lim];
    endfunction

endpackage

[rtl/core/pss_core.sv]
// pss_core: ramp state and single-pass next-level logic for the pump soft-start ramp
// depends on pss_pkg (types, percent-to-pwm table)

module pss_core #(
    parameter int UP_STEPS   = pss_pkg::UpStepsDef,
    parameter int HOLD_TICKS = pss_pkg::HoldTicksDef,
    parameter int DOWN_STEPS = pss_pkg::DownStepsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  pss_pkg::t_item   i_item,
    input  pss_pkg::t_cfg    i_cfg,
    output pss_pkg::t_result o_result
);

    localparam int MaxSteps   = (UP_STEPS > DOWN_STEPS) ? UP_STEPS : DOWN_STEPS;
    localparam int AccW       = $clog2(MaxSteps * pss_pkg::MidPercent + 1);
    // 2^21 > 50 * 127^2, so the reciprocal quotient is exact for every step
    localparam int RecipShift = 21;
    localparam int RecipW     = RecipShift + 1;
    localparam int ProdW      = AccW + RecipW;
    localparam int QW         = 6;
    localparam logic [RecipW-1:0] RecipUp =
        RecipW'(((1 << RecipShift) + UP_STEPS - 1) / UP_STEPS);
    localparam logic [RecipW-1:0] RecipDown =
        RecipW'(((1 << RecipShift) + DOWN_STEPS - 1) / DOWN_STEPS);
    localparam int PctW  = pss_pkg::PctW;
    localparam int StepW = pss_pkg::StepW;
    localparam logic [PctW-1:0] Mid = PctW'(pss_pkg::MidPercent);

    logic [pss_pkg::PwmW-1:0]    r_pwm,    n_pwm;
    pss_pkg::t_phase             r_phase,  n_phase;
    logic [StepW-1:0]            r_step,   n_step;
    logic [PctW-1:0]             r_start,  n_start;
    logic [pss_pkg::TargetW-1:0] r_target, n_target;
    logic [AccW-1:0]             r_acc,    n_acc;

    logic                    up_rising;
    logic [QW-1:0]           up_mag;
    logic [QW-1:0]           down_mag;
    logic [StepW-1:0]        step_inc;
    logic [AccW-1:0]         acc_sum;
    logic [RecipW-1:0]       recip;
    logic [ProdW-1:0]        prod;
    logic [QW-1:0]           quot;
    logic [PctW-1:0]         up_pct;
    logic [PctW-1:0]         down_pct;
    logic                    auto_mode;
    logic                    soft_start;
    logic [pss_pkg::ReqW-1:0] lvl;
    logic [14:0]             pwm_x100;
    logic [14:0]             div_sum;
    logic [PctW-1:0]         cur_pct;
    logic [PctW-1:0]         pct_sel;
    logic                    use_lut;

    // interpolation: acc holds step * |delta|, quotient by reciprocal
    always_comb begin
        up_rising = (r_start <= Mid);
        up_mag    = up_rising ? QW'(Mid - r_start) : QW'(r_start - Mid);
        down_mag  = QW'(Mid - PctW'(r_target));
        step_inc  = r_step + StepW'(1);
        acc_sum   = r_acc + ((r_phase == pss_pkg::PH_UP) ? AccW'(up_mag) : AccW'(down_mag));
        recip     = (r_phase == pss_pkg::PH_UP) ? RecipUp : RecipDown;
        prod      = ProdW'(acc_sum) * ProdW'(recip);
        quot      = prod[RecipShift +: QW];
        up_pct    = up_rising ? (r_start + PctW'(quot)) : (r_start - PctW'(quot));
        down_pct  = Mid - PctW'(quot);
    end

    // set command: clamp path and current percent (pwm * 100 / 255)
    always_comb begin
        auto_mode  = !i_item.manual_mode && !i_item.force_mode && !i_item.emergency_mode;
        soft_start = !i_item.manual_mode && (i_item.target_percent != '0) &&
                     (i_item.target_percent < pss_pkg::ReqW'(pss_pkg::MidPercent));
        lvl = i_item.target_percent;
        if (auto_mode) begin
            if ((lvl != '0) && (lvl < pss_pkg::ReqW'(i_cfg.pump_min_percent))) begin
                lvl = pss_pkg::ReqW'(i_cfg.pump_min_percent);
            end
            if (lvl > pss_pkg::ReqW'(i_cfg.pump_max_percent)) begin
                lvl = pss_pkg::ReqW'(i_cfg.pump_max_percent);
            end
        end
        if (lvl > pss_pkg::ReqW'(pss_pkg::MaxPercent)) begin
            lvl = pss_pkg::ReqW'(pss_pkg::MaxPercent);
        end
        pwm_x100 = 15'(r_pwm) * 15'd100;
        div_sum  = pwm_x100 + 15'd1 + (pwm_x100 >> 8);
        cur_pct  = div_sum[14:8];
    end

    always_comb begin
        n_pwm    = r_pwm;
        n_phase  = r_phase;
        n_step   = r_step;
        n_start  = r_start;
        n_target = r_target;
        n_acc    = r_acc;
        pct_sel  = lvl[PctW-1:0];
        use_lut  = 1'b0;
        if (i_item.func == pss_pkg::FUNC_SET) begin
            n_phase = pss_pkg::PH_IDLE;
            n_step  = '0;
            n_acc   = '0;
            use_lut = 1'b1;
            if (soft_start) begin
                n_start  = cur_pct;
                n_target = i_item.target_percent[pss_pkg::TargetW-1:0];
                n_phase  = pss_pkg::PH_UP;
                pct_sel  = cur_pct;
            end
        end else begin
            unique case (r_phase)
                pss_pkg::PH_UP: begin
                    n_step  = step_inc;
                    n_acc   = acc_sum;
                    pct_sel = up_pct;
                    use_lut = 1'b1;
                    if (step_inc >= StepW'(UP_STEPS)) begin
                        n_step  = '0;
                        n_acc   = '0;
                        n_phase = (HOLD_TICKS == 0) ? pss_pkg::PH_DOWN : pss_pkg::PH_HOLD;
                    end
                end
                pss_pkg::PH_HOLD: begin
                    n_step = step_inc;
                    if (step_inc >= StepW'(HOLD_TICKS)) begin
                        n_step  = '0;
                        n_phase = pss_pkg::PH_DOWN;
                        pct_sel = Mid;
                        use_lut = 1'b1;
                    end
                end
                pss_pkg::PH_DOWN: begin
                    n_step  = step_inc;
                    n_acc   = acc_sum;
                    pct_sel = down_pct;
                    use_lut = 1'b1;
                    if (step_inc >= StepW'(DOWN_STEPS)) begin
                        n_step  = '0;
                        n_acc   = '0;
                        n_phase = pss_pkg::PH_IDLE;
                    end
                end
                pss_pkg::PH_IDLE: begin
                    n_phase = pss_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = pss_pkg::PH_IDLE;
                end
            endcase
        end
        if (use_lut) begin
            n_pwm = pss_pkg::pct_to_pwm(pct_sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm    <= '0;
            r_phase  <= pss_pkg::PH_IDLE;
            r_step   <= '0;
            r_start  <= '0;
            r_target <= '0;
            r_acc    <= '0;
        end else if (i_en) begin
            r_pwm    <= n_pwm;
            r_phase  <= n_phase;
            r_step   <= n_step;
            r_start  <= n_start;
            r_target <= n_target;
            r_acc    <= n_acc;
        end
    end

    assign o_result.pwm_level = n_pwm;
    assign o_result.ramp_busy = (n_phase != pss_pkg::PH_IDLE);

endmodule

[rtl/core/pump_soft_start_ramp_top.sv]
// pump_soft_start_ramp_top: stream wrapper, input and result registers, config registers
// depends on pss_pkg and pss_core
//
//  channel   direction  transfer when                      contents
//  s_axis    in         s_axis_tvalid & s_axis_tready      set command or 50 ms tick
//  m_axis    out        m_axis_tvalid & m_axis_tready      pwm level and ramp busy flag
//  apb       in         psel & penable & pwrite & pready   pump min / max percent
//
//  one item per cycle sustained while m_axis does not stall; a result passes through the input register,
//  then the ramp update into the result register
//  the ramp state updates in the same cycle an item moves into the result register
//  reset clears both stages, the ramp state and the config registers
//  when m_axis stalls both stages fill, then s_axis_tready drops

module pump_soft_start_ramp_top #(
    parameter int UP_STEPS   = pss_pkg::UpStepsDef,
    parameter int HOLD_TICKS = pss_pkg::HoldTicksDef,
    parameter int DOWN_STEPS = pss_pkg::DownStepsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] target_percent, [8] manual_mode,
                                        // [9] force_mode, [10] emergency_mode, [15:11] zero
    input  logic [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] pwm_level, [8] ramp_busy, [15:9] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 r_in_valid;
    pss_pkg::t_item       r_in;
    logic                 r_out_valid;
    pss_pkg::t_result     r_out;
    pss_pkg::t_result     core_result;
    pss_pkg::t_cfg        r_cfg;
    pss_pkg::t_reg_idx    reg_idx;
    logic                 adv;
    logic                 in_xfer;
    logic                 cfg_wr;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.func           <= pss_pkg::t_func'(s_axis_tuser[0]);
            r_in.target_percent <= s_axis_tdata[7:0];
            r_in.manual_mode    <= s_axis_tdata[8];
            r_in.force_mode     <= s_axis_tdata[9];
            r_in.emergency_mode <= s_axis_tdata[10];
        end
    end

    pss_core #(
        .UP_STEPS   (UP_STEPS),
        .HOLD_TICKS (HOLD_TICKS),
        .DOWN_STEPS (DOWN_STEPS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.ramp_busy, r_out.pwm_level};

    // config port
    assign pready  = 1'b1;
    assign reg_idx = pss_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pump_min_percent <= pss_pkg::PctW'(pss_pkg::PumpMinReset);
            r_cfg.pump_max_percent <= pss_pkg::PctW'(pss_pkg::PumpMaxReset);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                pss_pkg::REG_PUMP_MIN: r_cfg.pump_min_percent <= pwdata[6:0];
                pss_pkg::REG_PUMP_MAX: r_cfg.pump_max_percent <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pss_pkg::REG_PUMP_MIN: prdata = {25'd0, r_cfg.pump_min_percent};
            pss_pkg::REG_PUMP_MAX: prdata = {25'd0, r_cfg.pump_max_percent};
            default:               prdata = '0;
        endcase
    end

endmodule

[rtl/core/pss_checker.sv]
// pss_checker: port-level checks on the pump soft-start ramp top level, and its bind
// depends on pump_soft_start_ramp_top port names

module pss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // no result is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // with the result slot empty the input side can never be blocked
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // a transfer into an empty pipe shows up at the output after the input register and then the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) ##1 !m_axis_tvalid |=> m_axis_tvalid)
        else $error("result missing after transfer");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind pump_soft_start_ramp_top pss_checker u_pss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
